### hw/rtl/poll_pulse_width_key_responder_top_macros.svh
// ---------------------------------------------------------------------------
// Poll responder assertion macros
// Shorthand for clocked concurrent assertions used by the port checker.
// ---------------------------------------------------------------------------
`ifndef POLL_PULSE_WIDTH_KEY_RESPONDER_TOP_MACROS_SVH
`define POLL_PULSE_WIDTH_KEY_RESPONDER_TOP_MACROS_SVH

// assertion disabled while reset is high
`define PWKR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that is also checked during reset
`define PWKR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pwkr_pkg.sv
// ---------------------------------------------------------------------------
// pwkr_pkg
// Shared types and constants of the poll-line key responder.
// ---------------------------------------------------------------------------
`default_nettype none

package pwkr_pkg;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_POLL = 2'd1,
      OP_PUSH = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_ZERO_LOW  = 3'd0,
      CSR_ZERO_HIGH = 3'd1,
      CSR_ONE_LOW   = 3'd2,
      CSR_ONE_HIGH  = 3'd3,
      CSR_TURN      = 3'd4,
      CSR_WINDOW    = 3'd5,
      CSR_STATUS    = 3'd6
   } csr_index_type;

   localparam int unsigned LEN_W    = 10;
   localparam int unsigned WINDOW_W = 16;
   localparam int unsigned KEY_W    = 8;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned RSP_W    = 16;
   localparam int unsigned QUEUED_W = 5;

   localparam logic [LEN_W-1:0]    ZERO_LOW_RST  = 10'd20;
   localparam logic [LEN_W-1:0]    ZERO_HIGH_RST = 10'd170;
   localparam logic [LEN_W-1:0]    ONE_LOW_RST   = 10'd95;
   localparam logic [LEN_W-1:0]    ONE_HIGH_RST  = 10'd95;
   localparam logic [LEN_W-1:0]    TURN_RST      = 10'd300;
   localparam logic [WINDOW_W-1:0] WINDOW_RST    = 16'd500;
   localparam logic [KEY_W-1:0]    STATUS_RST    = 8'hFD;

   localparam logic [3:0]          FRAME_BITS = 4'd8;
   localparam logic [WINDOW_W-1:0] SINCE_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [LEN_W-1:0]    zero_low;
      logic [LEN_W-1:0]    zero_high;
      logic [LEN_W-1:0]    one_low;
      logic [LEN_W-1:0]    one_high;
      logic [LEN_W-1:0]    turnaround;
      logic [WINDOW_W-1:0] window;
      logic [KEY_W-1:0]    status;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

`default_nettype wire

### hw/rtl/poll_pulse_width_key_responder_top.sv
// Data path: an accepted req_ transaction passes the input and result registers to rsp_.
// Throughput: one transaction per cycle unless rsp_ stalls; the state update and the
// skipping of zero-length bit intervals are both combinational, between the input
// and result registers.
// Reset: synchronous, active high; line released, timers, queue and counters
// cleared, configuration back to its default values.
// ---------------------------------------------------------------------------
// poll_pulse_width_key_responder_top
// Poll-line key responder: key queue, poll gap timer and pulse-width sender.
// ---------------------------------------------------------------------------
`default_nettype none

module poll_pulse_width_key_responder_top #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] key_code
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [0] line_drive, [1] line_level,
                                         // [2] responding, [7:3] queued_keys,
                                         // [8] key_dropped, [15:9] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

   pwkr_pkg::cfg_type          cfg;
   pwkr_pkg::fifo_ctl_type     fifo_ctl;
   pwkr_pkg::fifo_stat_type    fifo_stat;
   logic [pwkr_pkg::KEY_W-1:0] head_key;
   logic [CW-1:0]              count_next;
   logic [pwkr_pkg::KEY_W-1:0] u_core_key;

   pwkr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwkr_key_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fifo_ctl),
      .wr_data    (u_core_key),
      .rd_data    (head_key),
      .stat       (fifo_stat),
      .count_next (count_next)
   );

   pwkr_core #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fifo_ctl        (fifo_ctl),
      .fifo_stat       (fifo_stat),
      .fifo_head_key   (head_key),
      .fifo_count_next (count_next),
      .push_key        (u_core_key)
   );

endmodule

`default_nettype wire

### hw/rtl/pwkr_csr.sv
// ---------------------------------------------------------------------------
// pwkr_csr
// Configuration registers, written through the csr channel.
// ---------------------------------------------------------------------------
`default_nettype none

module pwkr_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [pwkr_pkg::CSR_W-1:0]  csr_data,
   output pwkr_pkg::cfg_type                cfg
);

   pwkr_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_low  <= pwkr_pkg::ZERO_LOW_RST;
         cfg_ff.zero_high <= pwkr_pkg::ZERO_HIGH_RST;
         cfg_ff.one_low   <= pwkr_pkg::ONE_LOW_RST;
         cfg_ff.one_high  <= pwkr_pkg::ONE_HIGH_RST;
         cfg_ff.turnaround <= pwkr_pkg::TURN_RST;
         cfg_ff.window    <= pwkr_pkg::WINDOW_RST;
         cfg_ff.status    <= pwkr_pkg::STATUS_RST;
      end else if (csr_valid) begin
         unique case (pwkr_pkg::csr_index_type'(csr_index))
            pwkr_pkg::CSR_ZERO_LOW:  cfg_ff.zero_low   <= csr_data[pwkr_pkg::LEN_W-1:0];
            pwkr_pkg::CSR_ZERO_HIGH: cfg_ff.zero_high  <= csr_data[pwkr_pkg::LEN_W-1:0];
            pwkr_pkg::CSR_ONE_LOW:   cfg_ff.one_low    <= csr_data[pwkr_pkg::LEN_W-1:0];
            pwkr_pkg::CSR_ONE_HIGH:  cfg_ff.one_high   <= csr_data[pwkr_pkg::LEN_W-1:0];
            pwkr_pkg::CSR_TURN:      cfg_ff.turnaround <= csr_data[pwkr_pkg::LEN_W-1:0];
            pwkr_pkg::CSR_WINDOW:    cfg_ff.window     <= csr_data[pwkr_pkg::WINDOW_W-1:0];
            pwkr_pkg::CSR_STATUS:    cfg_ff.status     <= csr_data[pwkr_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pwkr_key_fifo.sv
// ---------------------------------------------------------------------------
// pwkr_key_fifo
// Key code queue with registered head read and write-through bypass.
// ---------------------------------------------------------------------------
`default_nettype none

module pwkr_key_fifo #(
   parameter int unsigned FIFO_DEPTH = 16,
   localparam int unsigned AW = $clog2(FIFO_DEPTH),
   localparam int unsigned CW = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  pwkr_pkg::fifo_ctl_type           ctl,
   input  wire logic [pwkr_pkg::KEY_W-1:0]  wr_data,
   output logic [pwkr_pkg::KEY_W-1:0]       rd_data,
   output pwkr_pkg::fifo_stat_type          stat,
   output logic [CW-1:0]                    count_next
);

   localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

   logic [pwkr_pkg::KEY_W-1:0] mem [FIFO_DEPTH];
   logic [pwkr_pkg::KEY_W-1:0] rd_ff;
   logic [AW-1:0]              head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]              count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (ctl.push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign count_next = count_in;
   assign rd_data    = rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (ctl.push && (tail_ff == head_in)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pwkr_core.sv
// ---------------------------------------------------------------------------
// pwkr_core
// Input register, poll/bit sequencer state update and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pwkr_core #(
   parameter int unsigned FIFO_DEPTH = 16,
   localparam int unsigned CW = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  pwkr_pkg::cfg_type                cfg,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [pwkr_pkg::KEY_W-1:0]  req_tdata,
   input  wire logic [1:0]                  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [pwkr_pkg::RSP_W-1:0]       rsp_tdata,
   output pwkr_pkg::fifo_ctl_type           fifo_ctl,
   input  pwkr_pkg::fifo_stat_type          fifo_stat,
   input  wire logic [pwkr_pkg::KEY_W-1:0]  fifo_head_key,
   input  wire logic [CW-1:0]               fifo_count_next,
   output logic [pwkr_pkg::KEY_W-1:0]       push_key
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TURN = 2'd1,
      PH_LOW  = 2'd2,
      PH_HIGH = 2'd3
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [pwkr_pkg::LEN_W-1:0]       timer_ff, timer_in;
   logic [pwkr_pkg::WINDOW_W-1:0]    since_ff, since_in;
   logic [pwkr_pkg::KEY_W-1:0]       shift_ff, shift_in;
   logic [3:0]                       bits_ff, bits_in;

   logic                             in_valid_ff;
   pwkr_pkg::opcode_type             in_op_ff;
   logic [pwkr_pkg::KEY_W-1:0]       in_key_ff;

   logic                             rsp_valid_ff;
   logic [pwkr_pkg::RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic advance, fire, dropped;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic [pwkr_pkg::LEN_W-1:0] lo_len;
      logic [pwkr_pkg::LEN_W-1:0] hi_len;
      logic                       enter;
      logic                       done;

      phase_in = phase_ff;
      timer_in = timer_ff;
      since_in = since_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      fifo_ctl = '0;
      dropped  = 1'b0;
      lo_len   = '0;
      hi_len   = '0;
      enter    = 1'b0;
      done     = 1'b0;

      if (fire) begin
         unique case (in_op_ff)
            pwkr_pkg::OP_TICK: begin
               if (since_ff != pwkr_pkg::SINCE_MAX) begin
                  since_in = since_ff + 1'b1;
               end
               if (phase_ff != PH_IDLE && timer_ff != '0) begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            pwkr_pkg::OP_POLL: begin
               if (phase_ff == PH_IDLE) begin
                  since_in = '0;
                  if (since_ff < cfg.window) begin
                     shift_in = cfg.status;
                     bits_in  = pwkr_pkg::FRAME_BITS;
                     phase_in = PH_TURN;
                     timer_in = cfg.turnaround;
                  end else if (!fifo_stat.empty) begin
                     fifo_ctl.pop = 1'b1;
                     shift_in = fifo_head_key;
                     bits_in  = pwkr_pkg::FRAME_BITS;
                     phase_in = PH_TURN;
                     timer_in = cfg.turnaround;
                  end
               end
            end
            pwkr_pkg::OP_PUSH: begin
               if (fifo_stat.full) begin
                  dropped = 1'b1;
               end else begin
                  fifo_ctl.push = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // expired interval: step forward, skipping zero-length intervals
      if (phase_in != PH_IDLE && timer_in == '0) begin
         unique case (phase_in)
            PH_TURN: enter = 1'b1;
            PH_LOW: begin
               hi_len = shift_in[0] ? cfg.one_high : cfg.zero_high;
               if (hi_len != '0) begin
                  phase_in = PH_HIGH;
                  timer_in = hi_len;
               end else begin
                  shift_in = shift_in >> 1;
                  bits_in  = bits_in - 1'b1;
                  enter    = 1'b1;
               end
            end
            PH_HIGH: begin
               shift_in = shift_in >> 1;
               bits_in  = bits_in - 1'b1;
               enter    = 1'b1;
            end
            default: ;
         endcase

         if (enter) begin
            for (int i = 0; i <= 8; i++) begin
               if (!done) begin
                  lo_len = shift_in[0] ? cfg.one_low : cfg.zero_low;
                  hi_len = shift_in[0] ? cfg.one_high : cfg.zero_high;
                  if (bits_in == '0) begin
                     phase_in = PH_IDLE;
                     timer_in = '0;
                     done     = 1'b1;
                  end else if (lo_len != '0) begin
                     phase_in = PH_LOW;
                     timer_in = lo_len;
                     done     = 1'b1;
                  end else if (hi_len != '0) begin
                     phase_in = PH_HIGH;
                     timer_in = hi_len;
                     done     = 1'b1;
                  end else begin
                     shift_in = shift_in >> 1;
                     bits_in  = bits_in - 1'b1;
                  end
               end
            end
            if (!done) begin
               phase_in = PH_IDLE;
               timer_in = '0;
            end
         end
      end

      rsp_data_in      = '0;
      rsp_data_in[0]   = (phase_in == PH_LOW) || (phase_in == PH_HIGH);
      rsp_data_in[1]   = (phase_in == PH_HIGH);
      rsp_data_in[2]   = (phase_in != PH_IDLE);
      rsp_data_in[7:3] = pwkr_pkg::QUEUED_W'(fifo_count_next);
      rsp_data_in[8]   = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         since_ff     <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         since_ff <= since_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff  <= pwkr_pkg::opcode_type'(req_tuser);
         in_key_ff <= req_tdata;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign push_key = in_key_ff;

endmodule

`default_nettype wire

### hw/rtl/pwkr_checker.sv
// ---------------------------------------------------------------------------
// pwkr_checker
// Port-level checks of the poll responder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "poll_pulse_width_key_responder_top_macros.svh"

module pwkr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   `PWKR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp transaction changed while stalled")

   `PWKR_ASSERT(a_level_needs_drive, clock, reset, rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]), "line level high while line released")

   `PWKR_ASSERT(a_drive_needs_resp, clock, reset, rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[2]), "line driven outside a response")

   `PWKR_ASSERT_NR(a_reset_clears, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind poll_pulse_width_key_responder_top pwkr_checker u_pwkr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### bench/poll_line_sb_pkg.sv
// ---------------------------------------------------------------------------
// Poll responder scoreboard
// Tracks line state, poll gap timer and key queue of the responder for each
// accepted request, and checks every response against the oldest prediction.
// ---------------------------------------------------------------------------
package poll_line_sb_pkg;
   import pwkr_pkg::*;

   typedef enum logic [1:0] {
      SEND_IDLE,
      SEND_TURN,
      SEND_LOW,
      SEND_HIGH
   } send_phase_type;

   typedef struct packed {
      logic                key_dropped;
      logic [QUEUED_W-1:0] queued_keys;
      logic                responding;
      logic                line_level;
      logic                line_drive;
   } line_state_type;

   localparam int unsigned KEY_SLOTS = 16;

   class poll_line_scoreboard;
      cfg_type             cfg;
      send_phase_type      phase;
      logic [LEN_W-1:0]    interval_left;
      logic [WINDOW_W-1:0] since_poll;
      logic [KEY_W-1:0]    frame_bits;
      logic [3:0]          bits_left;
      logic [KEY_W-1:0]    key_slots [KEY_SLOTS];
      int unsigned         rd_ptr;
      int unsigned         wr_ptr;
      int unsigned         key_count;
      line_state_type      expected_states [$];
      int unsigned         failures;

      function new();
         cfg = '{zero_low: ZERO_LOW_RST, zero_high: ZERO_HIGH_RST, one_low: ONE_LOW_RST,
                 one_high: ONE_HIGH_RST, turnaround: TURN_RST, window: WINDOW_RST,
                 status: STATUS_RST};
         phase         = SEND_IDLE;
         interval_left = '0;
         since_poll    = '0;
         frame_bits    = '0;
         bits_left     = '0;
         rd_ptr        = 0;
         wr_ptr        = 0;
         key_count     = 0;
         failures      = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_ZERO_LOW:  cfg.zero_low   = value[LEN_W-1:0];
            CSR_ZERO_HIGH: cfg.zero_high  = value[LEN_W-1:0];
            CSR_ONE_LOW:   cfg.one_low    = value[LEN_W-1:0];
            CSR_ONE_HIGH:  cfg.one_high   = value[LEN_W-1:0];
            CSR_TURN:      cfg.turnaround = value[LEN_W-1:0];
            CSR_WINDOW:    cfg.window     = value[WINDOW_W-1:0];
            CSR_STATUS:    cfg.status     = value[KEY_W-1:0];
            default: ;
         endcase
      endfunction

      function void begin_low();
         phase         = SEND_LOW;
         interval_left = frame_bits[0] ? cfg.one_low : cfg.zero_low;
      endfunction

      // step past every interval that has run out, zero-length ones included
      function void settle();
         while (phase != SEND_IDLE && interval_left == 0) begin
            case (phase)
               SEND_TURN: begin_low();
               SEND_LOW: begin
                  phase         = SEND_HIGH;
                  interval_left = frame_bits[0] ? cfg.one_high : cfg.zero_high;
               end
               default: begin
                  frame_bits = frame_bits >> 1;
                  bits_left  = bits_left - 4'd1;
                  if (bits_left == 0) begin
                     phase         = SEND_IDLE;
                     interval_left = '0;
                  end else begin
                     begin_low();
                  end
               end
            endcase
         end
      endfunction

      function void start_frame(logic [KEY_W-1:0] frame);
         frame_bits    = frame;
         bits_left     = FRAME_BITS;
         phase         = SEND_TURN;
         interval_left = cfg.turnaround;
         settle();
      endfunction

      function void apply_request(opcode_type op, logic [KEY_W-1:0] key);
         line_state_type      state;
         logic                dropped;
         logic [WINDOW_W-1:0] gap;
         dropped = 1'b0;
         case (op)
            OP_TICK: begin
               if (since_poll != SINCE_MAX) since_poll++;
               if (phase != SEND_IDLE) begin
                  if (interval_left != 0) interval_left--;
                  settle();
               end
            end
            OP_POLL: begin
               if (phase == SEND_IDLE) begin
                  gap        = since_poll;
                  since_poll = '0;
                  if (gap < cfg.window) begin
                     start_frame(cfg.status);
                  end else if (key_count != 0) begin
                     start_frame(key_slots[rd_ptr]);
                     rd_ptr = (rd_ptr + 1) % KEY_SLOTS;
                     key_count--;
                  end
               end
            end
            OP_PUSH: begin
               if (key_count >= KEY_SLOTS) begin
                  dropped = 1'b1;
               end else begin
                  key_slots[wr_ptr] = key;
                  wr_ptr = (wr_ptr + 1) % KEY_SLOTS;
                  key_count++;
               end
            end
            default: ;
         endcase
         state.line_drive  = (phase == SEND_LOW) || (phase == SEND_HIGH);
         state.line_level  = (phase == SEND_HIGH);
         state.responding  = (phase != SEND_IDLE);
         state.queued_keys = QUEUED_W'(key_count);
         state.key_dropped = dropped;
         expected_states.push_back(state);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] data);
         line_state_type got;
         line_state_type want;
         got = data[8:0];
         if (expected_states.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, data);
            failures++;
            return;
         end
         want = expected_states.pop_front();
         compare_field("line_drive", want.line_drive, got.line_drive);
         compare_field("line_level", want.line_level, got.line_level);
         compare_field("responding", want.responding, got.responding);
         compare_field("queued_keys", want.queued_keys, got.queued_keys);
         compare_field("key_dropped", want.key_dropped, got.key_dropped);
         compare_field("pad bits", 0, data[RSP_W-1:9]);
      endfunction

      function int unsigned pending();
         return expected_states.size();
      endfunction
   endclass

endpackage

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives ticks, polls and key pushes into the poll responder under several
// register settings and random backpressure, predicts every line state
// transaction and checks it field by field.
// ---------------------------------------------------------------------------
module tb_top;
   import pwkr_pkg::*;
   import poll_line_sb_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned PRESSURE_CYCLES = 200;
   localparam int unsigned PHASE_ITEMS     = 280;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 88;
   bit          hold_request  = 1'b0;
   bit          hold_done     = 1'b0;
   int unsigned stall_left    = 0;
   int unsigned cycle_count   = 0;
   int unsigned sent_items    = 0;
   logic [15:0] csr_plan [7];

   poll_line_scoreboard line_sb = new();

   poll_pulse_width_key_responder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) line_sb.check_response(rsp_tdata);
   end

   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         stall_left = PRESSURE_CYCLES;
         hold_done  = 1'b1;
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // entered and left at a falling edge
   task automatic send_item(opcode_type op, logic [7:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      line_sb.apply_request(op, key);
      if (op != OP_NOP) sent_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (line_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csrs();
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data  <= csr_plan[i];
         do @(posedge clock); while (!csr_ready);
         line_sb.set_register(csr_index_type'(i), csr_plan[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_plan(int unsigned zl, int unsigned zh, int unsigned ol, int unsigned oh,
                           int unsigned turn, int unsigned window, int unsigned status);
      csr_plan[CSR_ZERO_LOW]  = 16'(zl);
      csr_plan[CSR_ZERO_HIGH] = 16'(zh);
      csr_plan[CSR_ONE_LOW]   = 16'(ol);
      csr_plan[CSR_ONE_HIGH]  = 16'(oh);
      csr_plan[CSR_TURN]      = 16'(turn);
      csr_plan[CSR_WINDOW]    = 16'(window);
      csr_plan[CSR_STATUS]    = 16'(status);
      write_csrs();
   endtask

   task automatic short_timing_plan();
      set_plan($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
               $urandom_range(1, 3), $urandom_range(0, 4), $urandom_range(1, 40),
               $urandom_range(255));
   endtask

   // mostly tick runs closed by a poll, with key bursts, double polls and noise
   task automatic random_traffic(int unsigned quota);
      int unsigned first;
      int unsigned pick;
      int unsigned n;
      first = sent_items;
      while (sent_items - first < quota) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            n = $urandom_range(1, 50);
            repeat (n) send_item(OP_TICK, 8'($urandom));
            send_item(OP_POLL, 8'($urandom));
         end else if (pick < 75) begin
            n = ($urandom_range(7) == 0) ? 18 : $urandom_range(1, 5);
            repeat (n) send_item(OP_PUSH, 8'($urandom));
         end else if (pick < 85) begin
            send_item(OP_POLL, 8'($urandom));
            n = $urandom_range(0, 3);
            repeat (n) send_item(OP_TICK, 8'($urandom));
            send_item(OP_POLL, 8'($urandom));
         end else begin
            send_item(opcode_type'($urandom_range(3)), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset register values
      send_item(OP_PUSH, 8'hFF);
      send_item(OP_PUSH, 8'h00);
      send_item(OP_NOP, 8'hAA);
      repeat (3) send_item(OP_TICK, 8'h55);
      drain();

      // zero turnaround, status frame of all zeros
      set_plan(1, 2, 2, 1, 0, 4, 8'h00);
      send_item(OP_POLL, 8'h00);
      send_item(OP_POLL, 8'hFF);
      repeat (30) send_item(OP_TICK, 8'h00);
      send_item(OP_POLL, 8'h00);
      repeat (30) send_item(OP_TICK, 8'h00);
      send_item(OP_POLL, 8'h00);
      repeat (30) send_item(OP_TICK, 8'h00);
      send_item(OP_POLL, 8'h00);
      send_item(OP_POLL, 8'h00);
      repeat (30) send_item(OP_TICK, 8'h00);
      for (int k = 0; k < 17; k++) send_item(OP_PUSH, 8'(k * 15));
      drain();

      short_timing_plan();
      random_traffic(PHASE_ITEMS);
      drain();

      send_idle_pct = 88;
      recv_idle_pct = 6;
      short_timing_plan();
      random_traffic(PHASE_ITEMS);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      short_timing_plan();
      hold_request = 1'b1;
      random_traffic(PHASE_ITEMS);
      drain();

      set_plan(1, 1, 1, 1, 0, 1, 8'hFF);
      random_traffic(60);
      drain();

      // longest intervals and widest window; a poll in the turnaround is ignored
      set_plan(1023, 1023, 1023, 1023, 1023, 16'hFFFF, 8'h00);
      send_item(OP_PUSH, 8'h81);
      repeat (20) send_item(OP_TICK, 8'h00);
      send_item(OP_POLL, 8'h00);
      repeat (20) send_item(OP_TICK, 8'h00);
      send_item(OP_POLL, 8'h00);
      send_item(OP_TICK, 8'h00);
      drain();

      if (line_sb.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
